[rtl/core/morse_code_codec_top_assert.svh]
// ----------------------------------------------------------------------------
// morse code codec assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef MORSE_CODE_CODEC_TOP_ASSERT_SVH
`define MORSE_CODE_CODEC_TOP_ASSERT_SVH

// condition in the same cycle
`define MCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition in the next cycle
`define MCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/mcc_pkg.sv]
// ----------------------------------------------------------------------------
// mcc_pkg
// shared widths, character codes, commands and job types of the morse codec
// ----------------------------------------------------------------------------
`default_nettype none

package mcc_pkg;

	localparam int MAX_CODE_LEN_DEF = 6;
	localparam int CMD_W            = 2;
	localparam int CHAR_W           = 8;
	localparam int CODE_W           = 6;
	localparam int LEN_W            = 3;
	localparam int SYM_COUNT        = 256;
	localparam int JOBQ_DEPTH       = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_DECODE = 2'd1,
		CMD_ENCODE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// ascii codes
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CASE_OFS = 8'h20;

	// work handed from the front to the back
	typedef enum logic [2:0] {
		JOB_LOAD  = 3'd0,
		JOB_CLOSE = 3'd1,
		JOB_SPACE = 3'd2,
		JOB_ENC   = 3'd3,
		JOB_NL    = 3'd4,
		JOB_CLEAR = 3'd5
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic      lost;
		logic      nl;
	} job_ctl_t;

	function automatic logic [CHAR_W-1:0] to_upper(input logic [CHAR_W-1:0] c);
		if (c >= CH_LC_A && c <= CH_LC_Z) begin
			return c - CASE_OFS;
		end
		return c;
	endfunction

	function automatic logic is_sep(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) ||
			(c == CH_VT) || (c == CH_FF) || (c == CH_NL);
	endfunction

endpackage

`default_nettype wire

[rtl/core/mcc_ram.sv]
// ----------------------------------------------------------------------------
// mcc_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/mcc_queue.sv]
// ----------------------------------------------------------------------------
// mcc_queue
// short first-in first-out job queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] pop_data,
	output logic                  not_empty,
	output logic                  full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CW'(DEPTH));
	assign pop_data  = entry_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

[rtl/core/mcc_front.sv]
// ----------------------------------------------------------------------------
// mcc_front
// accepts input words, keeps the trie presence map and the decode walk,
// and hands the work that produces results or touches the tables to the back
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_front #(
	parameter int MAX_CODE_LEN = mcc_pkg::MAX_CODE_LEN_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [mcc_pkg::CMD_W-1:0]   cmd,
	input  wire logic [mcc_pkg::CHAR_W-1:0]  char_in,
	input  wire logic [mcc_pkg::CODE_W-1:0]  code_bits,
	input  wire logic [mcc_pkg::LEN_W-1:0]   code_len,
	input  wire logic                        q_full,
	output logic                             q_push,
	output mcc_pkg::job_ctl_t                job_ctl,
	output logic      [MAX_CODE_LEN:0]       job_idx,
	output logic      [mcc_pkg::CHAR_W-1:0]  job_sym
);

	import mcc_pkg::*;

	localparam int IDX_W      = MAX_CODE_LEN + 1;
	localparam int NODE_COUNT = (2 ** IDX_W) - 1;
	localparam int CODE_DEPTH = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	logic [NODE_COUNT-1:0] present_q;
	logic [IDX_W-1:0]      walk_q;
	logic                  in_word_q;
	logic                  lost_q;

	logic                  accept;
	logic                  load_ok;
	logic [NODE_COUNT-1:0] path_mask;
	logic [IDX_W-1:0]      path_idx;
	logic                  sep;
	logic                  step;
	logic [IDX_W:0]        nx;
	logic [NODE_COUNT:0]   present_pad;
	logic                  nx_ok;

	assign in_ready    = !q_full;
	assign accept      = in_valid && in_ready;
	assign load_ok     = (code_len <= LEN_W'(CODE_DEPTH));
	assign sep         = is_sep(char_in);
	assign step        = (char_in == CH_DOT) || (char_in == CH_DASH);
	assign present_pad = {1'b0, present_q};

	// nodes on the load path
	always_comb begin
		path_idx  = '0;
		path_mask = '0;
		for (int d = 0; d < CODE_DEPTH; d++) begin
			if (d < int'(code_len)) begin
				path_idx = {path_idx[IDX_W-2:0], 1'b0} + IDX_W'(1) + IDX_W'(code_bits[d]);
				path_mask[path_idx] = 1'b1;
			end
		end
	end

	// next decode node and whether it exists
	always_comb begin
		nx    = {walk_q, 1'b0} +
			((char_in == CH_DASH) ? (IDX_W+1)'(2) : (IDX_W+1)'(1));
		nx_ok = (nx < (IDX_W+1)'(NODE_COUNT)) && present_pad[nx[IDX_W-1:0]];
	end

	// job issue
	always_comb begin
		q_push  = 1'b0;
		job_ctl = '{kind: JOB_LOAD, lost: 1'b0, nl: 1'b0};
		job_idx = path_idx;
		job_sym = to_upper(char_in);
		case (cmd_t'(cmd))
			CMD_LOAD: begin
				q_push = accept && load_ok;
			end
			CMD_DECODE: begin
				job_idx     = walk_q;
				job_ctl.nl  = (char_in == CH_NL);
				job_ctl.lost = lost_q;
				if (sep && in_word_q) begin
					q_push       = accept;
					job_ctl.kind = JOB_CLOSE;
				end else if (sep && (char_in == CH_NL)) begin
					q_push       = accept;
					job_ctl.kind = JOB_SPACE;
				end
			end
			CMD_ENCODE: begin
				q_push       = accept;
				job_ctl.kind = ((char_in == CH_SPACE) || (char_in == CH_NL)) ?
					JOB_NL : JOB_ENC;
			end
			CMD_CLEAR: begin
				q_push       = accept;
				job_ctl.kind = JOB_CLEAR;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// presence map and decode walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= NODE_COUNT'(1);
			walk_q    <= '0;
			in_word_q <= 1'b0;
			lost_q    <= 1'b0;
		end else if (accept) begin
			case (cmd_t'(cmd))
				CMD_LOAD: begin
					if (load_ok) begin
						present_q <= present_q | path_mask;
					end
				end
				CMD_DECODE: begin
					if (sep) begin
						walk_q    <= '0;
						in_word_q <= 1'b0;
						lost_q    <= 1'b0;
					end else begin
						in_word_q <= 1'b1;
						if (step && !lost_q) begin
							if (nx_ok) begin
								walk_q <= nx[IDX_W-1:0];
							end else begin
								lost_q <= 1'b1;
							end
						end
					end
				end
				CMD_CLEAR: begin
					present_q <= NODE_COUNT'(1);
					walk_q    <= '0;
					in_word_q <= 1'b0;
					lost_q    <= 1'b0;
				end
				default: begin
					walk_q <= walk_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/mcc_back.sv]
// ----------------------------------------------------------------------------
// mcc_back
// carries out queued jobs: symbol and code tables, reverse table refresh by
// a preorder sweep, and result generation into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module mcc_back #(
	parameter int MAX_CODE_LEN = mcc_pkg::MAX_CODE_LEN_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_valid,
	input  wire mcc_pkg::job_ctl_t          q_ctl,
	input  wire logic [MAX_CODE_LEN:0]      q_idx,
	input  wire logic [mcc_pkg::CHAR_W-1:0] q_sym,
	output logic                            q_pop,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [mcc_pkg::CHAR_W-1:0] out_char,
	output logic                            unknown,
	output logic                            last
);

	import mcc_pkg::*;

	localparam int IDX_W      = MAX_CODE_LEN + 1;
	localparam int NODE_COUNT = (2 ** IDX_W) - 1;
	localparam int CODE_DEPTH = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int CWORD_W    = LEN_W + CODE_W;

	typedef enum logic [5:0] {
		ST_RUN   = 6'b000001,
		ST_LD_WR = 6'b000010,
		ST_SWEEP = 6'b000100,
		ST_FIN   = 6'b001000,
		ST_WR_A  = 6'b010000,
		ST_WR_B  = 6'b100000
	} state_t;

	state_t                state_q;
	logic [NODE_COUNT-1:0] written_q;
	logic [SYM_COUNT-1:0]  code_vld_q;

	// load context
	logic [IDX_W-1:0]   ld_idx_q;
	logic [CHAR_W-1:0]  ld_sym_q;
	logic               ld_wr_q;
	logic [CHAR_W-1:0]  tgt_a_q;
	logic [CHAR_W-1:0]  tgt_b_q;
	logic               en_a_q;
	logic               en_b_q;
	logic               found_a_q;
	logic               found_b_q;
	logic [CWORD_W-1:0] code_a_q;
	logic [CWORD_W-1:0] code_b_q;

	// sweep position and probe in flight
	logic [LEN_W-1:0]   sw_len_q;
	logic [CODE_W-1:0]  sw_bits_q;
	logic               probe_vld_s2;
	logic [LEN_W-1:0]   probe_len_s2;
	logic [CODE_W-1:0]  probe_bits_s2;
	logic               probe_wr_s2;

	// result stage
	logic               job_vld_s2;
	job_kind_t          job_kind_s2;
	logic               job_lost_s2;
	logic               job_nl_s2;
	logic               job_hit_s2;
	logic [LEN_W-1:0]   job_cnt_s2;

	logic               out_vld_q;
	logic [CHAR_W-1:0]  out_char_q;
	logic               out_unk_q;
	logic               out_last_q;

	// ram ports
	logic               node_we;
	logic [IDX_W-1:0]   node_waddr;
	logic [CHAR_W-1:0]  node_wdata;
	logic               node_re;
	logic [IDX_W-1:0]   node_raddr;
	logic [CHAR_W-1:0]  node_rdata;
	logic               code_we;
	logic [CHAR_W-1:0]  code_waddr;
	logic [CWORD_W-1:0] code_wdata;
	logic               code_re;
	logic [CWORD_W-1:0] code_rdata;

	logic               res_job;
	logic               s2_done;
	logic               issue;
	logic               sys_go;
	logic [IDX_W-1:0]   sw_idx;
	logic [LEN_W-1:0]   nxt_len;
	logic [CODE_W-1:0]  nxt_bits;
	logic               sw_more;
	logic [CHAR_W-1:0]  old_sym;
	logic               ld_en_a;
	logic               ld_en_b;
	logic [CHAR_W-1:0]  probe_sym;
	logic [CHAR_W-1:0]  res_char;
	logic               res_unk;
	logic               res_last;
	logic               out_ld;

	mcc_ram #(
		.WIDTH (CHAR_W),
		.DEPTH (NODE_COUNT)
	) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (node_re),
		.raddr (node_raddr),
		.rdata (node_rdata)
	);

	mcc_ram #(
		.WIDTH (CWORD_W),
		.DEPTH (SYM_COUNT)
	) u_code_ram (
		.clk   (clk),
		.we    (code_we),
		.waddr (code_waddr),
		.wdata (code_wdata),
		.re    (code_re),
		.raddr (q_sym),
		.rdata (code_rdata)
	);

	// heap index of the sweep path
	always_comb begin
		sw_idx = '0;
		for (int d = 0; d < CODE_DEPTH; d++) begin
			if (d < int'(sw_len_q)) begin
				sw_idx = {sw_idx[IDX_W-2:0], 1'b0} + IDX_W'(1) + IDX_W'(sw_bits_q[d]);
			end
		end
	end

	// preorder successor: descend on a dot, else turn the deepest dot into a dash
	always_comb begin
		int kk;
		kk       = 0;
		sw_more  = 1'b0;
		nxt_len  = sw_len_q;
		nxt_bits = sw_bits_q;
		if (sw_len_q < LEN_W'(CODE_DEPTH)) begin
			sw_more = 1'b1;
			nxt_len = sw_len_q + LEN_W'(1);
		end else begin
			for (int k = 0; k < CODE_DEPTH; k++) begin
				if (!sw_bits_q[k]) begin
					sw_more = 1'b1;
					kk      = k;
				end
			end
			nxt_len = LEN_W'(kk + 1);
			for (int k = 0; k < CODE_W; k++) begin
				nxt_bits[k] = (k < kk) ? sw_bits_q[k] : (k == kk);
			end
		end
	end

	// job dispatch
	always_comb begin
		res_job = (q_ctl.kind == JOB_CLOSE) || (q_ctl.kind == JOB_SPACE) ||
			(q_ctl.kind == JOB_ENC) || (q_ctl.kind == JOB_NL);
		issue   = (state_q == ST_RUN) && q_valid && res_job && (!job_vld_s2 || s2_done);
		sys_go  = (state_q == ST_RUN) && q_valid && !res_job && !job_vld_s2;
		q_pop   = issue || sys_go;

		node_re    = (issue && (q_ctl.kind == JOB_CLOSE)) ||
			(sys_go && (q_ctl.kind == JOB_LOAD)) || (state_q == ST_SWEEP);
		node_raddr = (state_q == ST_SWEEP) ? sw_idx : q_idx;
		node_we    = (state_q == ST_LD_WR);
		node_waddr = ld_idx_q;
		node_wdata = ld_sym_q;

		code_re    = issue && (q_ctl.kind == JOB_ENC);
		code_we    = ((state_q == ST_WR_A) && en_a_q) || ((state_q == ST_WR_B) && en_b_q);
		code_waddr = (state_q == ST_WR_A) ? tgt_a_q : tgt_b_q;
		code_wdata = (state_q == ST_WR_A) ? code_a_q : code_b_q;
	end

	// symbols displaced and placed by a load
	always_comb begin
		old_sym   = ld_wr_q ? node_rdata : CH_NUL;
		ld_en_a   = (old_sym != CH_NUL) && (old_sym != ld_sym_q);
		ld_en_b   = (ld_sym_q != CH_NUL);
		probe_sym = probe_wr_s2 ? node_rdata : CH_NUL;
	end

	// result of the current stage word
	always_comb begin
		logic [LEN_W-1:0]  last_cnt;
		logic [LEN_W-1:0]  enc_len;
		logic [CODE_W-1:0] enc_bits;
		enc_len  = code_rdata[CWORD_W-1:CODE_W];
		enc_bits = code_rdata[CODE_W-1:0];
		last_cnt = '0;
		res_char = CH_SPACE;
		res_unk  = 1'b0;
		case (job_kind_s2)
			JOB_CLOSE: begin
				last_cnt = job_nl_s2 ? LEN_W'(1) : LEN_W'(0);
				if (job_cnt_s2 == '0) begin
					res_unk  = job_lost_s2;
					res_char = (job_lost_s2 || !job_hit_s2) ? CH_NUL : node_rdata;
				end
			end
			JOB_SPACE: begin
				res_char = CH_SPACE;
			end
			JOB_NL: begin
				res_char = CH_NL;
			end
			JOB_ENC: begin
				if (job_hit_s2) begin
					last_cnt = enc_len;
					if (job_cnt_s2 < enc_len) begin
						res_char = enc_bits[job_cnt_s2] ? CH_DASH : CH_DOT;
					end
				end else begin
					res_unk = 1'b1;
				end
			end
			default: begin
				res_char = CH_NUL;
			end
		endcase
		res_last = (job_cnt_s2 == last_cnt);
		out_ld   = job_vld_s2 && (!out_vld_q || out_ready);
		s2_done  = out_ld && res_last;
	end

	assign out_valid = out_vld_q;
	assign out_char  = out_char_q;
	assign unknown   = out_unk_q;
	assign last      = out_last_q;

	// sequencer, table valid bits and sweep match flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_RUN;
			written_q    <= '0;
			code_vld_q   <= '0;
			probe_vld_s2 <= 1'b0;
			found_a_q    <= 1'b0;
			found_b_q    <= 1'b0;
			en_a_q       <= 1'b0;
			en_b_q       <= 1'b0;
		end else begin
			probe_vld_s2 <= (state_q == ST_SWEEP);
			if (probe_vld_s2) begin
				if (en_a_q && !found_a_q && (probe_sym == tgt_a_q)) begin
					found_a_q <= 1'b1;
				end
				if (en_b_q && !found_b_q && (probe_sym == tgt_b_q)) begin
					found_b_q <= 1'b1;
				end
			end
			case (state_q)
				ST_RUN: begin
					if (sys_go && (q_ctl.kind == JOB_CLEAR)) begin
						written_q  <= '0;
						code_vld_q <= '0;
					end else if (sys_go && (q_ctl.kind == JOB_LOAD)) begin
						state_q <= ST_LD_WR;
					end
				end
				ST_LD_WR: begin
					written_q[ld_idx_q] <= 1'b1;
					en_a_q    <= ld_en_a;
					en_b_q    <= ld_en_b;
					found_a_q <= 1'b0;
					found_b_q <= 1'b0;
					state_q   <= (ld_en_a || ld_en_b) ? ST_SWEEP : ST_RUN;
				end
				ST_SWEEP: begin
					if (!sw_more) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_WR_A;
				end
				ST_WR_A: begin
					if (en_a_q) begin
						code_vld_q[tgt_a_q] <= found_a_q;
					end
					state_q <= ST_WR_B;
				end
				ST_WR_B: begin
					if (en_b_q) begin
						code_vld_q[tgt_b_q] <= found_b_q;
					end
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// load context, sweep path and matched codes
	always_ff @(posedge clk) begin
		if (sys_go) begin
			ld_idx_q <= q_idx;
			ld_sym_q <= q_sym;
			ld_wr_q  <= written_q[q_idx];
		end
		if (state_q == ST_LD_WR) begin
			tgt_a_q   <= old_sym;
			tgt_b_q   <= ld_sym_q;
			sw_len_q  <= '0;
			sw_bits_q <= '0;
		end
		if (state_q == ST_SWEEP) begin
			probe_len_s2  <= sw_len_q;
			probe_bits_s2 <= sw_bits_q;
			probe_wr_s2   <= written_q[sw_idx];
			sw_len_q      <= nxt_len;
			sw_bits_q     <= nxt_bits;
		end
		if (probe_vld_s2 && en_a_q && !found_a_q && (probe_sym == tgt_a_q)) begin
			code_a_q <= {probe_len_s2, probe_bits_s2};
		end
		if (probe_vld_s2 && en_b_q && !found_b_q && (probe_sym == tgt_b_q)) begin
			code_b_q <= {probe_len_s2, probe_bits_s2};
		end
	end

	// result stage and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_s2 <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (issue) begin
				job_vld_s2 <= 1'b1;
			end else if (s2_done) begin
				job_vld_s2 <= 1'b0;
			end
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// result stage and output register payload
	always_ff @(posedge clk) begin
		if (issue) begin
			job_kind_s2 <= q_ctl.kind;
			job_lost_s2 <= q_ctl.lost;
			job_nl_s2   <= q_ctl.nl;
			job_cnt_s2  <= '0;
			job_hit_s2  <= (q_ctl.kind == JOB_CLOSE) ? written_q[q_idx] : code_vld_q[q_sym];
		end else if (out_ld) begin
			job_cnt_s2 <= job_cnt_s2 + LEN_W'(1);
		end
		if (out_ld) begin
			out_char_q <= res_char;
			out_unk_q  <= res_unk;
			out_last_q <= res_last;
		end
	end

endmodule

`default_nettype wire

[rtl/core/morse_code_codec_top.sv]
// ----------------------------------------------------------------------------
// morse_code_codec_top
// morse encoder and decoder with a loadable trie dictionary
// ----------------------------------------------------------------------------
// Decode and encode words are taken one per cycle while the job queue has room;
// result words leave the output register one per cycle while out_ready is high.
// An encode of an n element code yields n+1 result words and a newline that
// closes a codeword yields two. A load that places or displaces a symbol has
// the reverse table refreshed by a dot-first preorder sweep of the node symbol
// memory through its single read port. Up to four words wait in the job queue
// behind a load; words that make no result and touch no table (dots, dashes)
// never enter it. Both tables are cleared at once by valid bits, so there is no
// clearing pass after reset.
`default_nettype none

`include "morse_code_codec_top_assert.svh"

module morse_code_codec_top #(
	parameter int MAX_CODE_LEN = mcc_pkg::MAX_CODE_LEN_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [mcc_pkg::CMD_W-1:0]  cmd,
	input  wire logic [mcc_pkg::CHAR_W-1:0] char_in,
	input  wire logic [mcc_pkg::CODE_W-1:0] code_bits,
	input  wire logic [mcc_pkg::LEN_W-1:0]  code_len,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [mcc_pkg::CHAR_W-1:0] out_char,
	output logic                            unknown,
	output logic                            last
);

	import mcc_pkg::*;

	localparam int IDX_W = MAX_CODE_LEN + 1;
	localparam int JOB_W = $bits(job_ctl_t) + IDX_W + CHAR_W;

	logic              q_push;
	logic              q_pop;
	logic              q_full;
	logic              q_valid;
	job_ctl_t          f_ctl;
	logic [IDX_W-1:0]  f_idx;
	logic [CHAR_W-1:0] f_sym;
	job_ctl_t          q_ctl;
	logic [IDX_W-1:0]  q_idx;
	logic [CHAR_W-1:0] q_sym;
	logic [JOB_W-1:0]  q_wdata;
	logic [JOB_W-1:0]  q_rdata;

	assign q_wdata = {f_ctl, f_idx, f_sym};
	assign {q_ctl, q_idx, q_sym} = q_rdata;

	mcc_front #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.char_in   (char_in),
		.code_bits (code_bits),
		.code_len  (code_len),
		.q_full    (q_full),
		.q_push    (q_push),
		.job_ctl   (f_ctl),
		.job_idx   (f_idx),
		.job_sym   (f_sym)
	);

	mcc_queue #(
		.WIDTH (JOB_W),
		.DEPTH (JOBQ_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.not_empty (q_valid),
		.full      (q_full)
	);

	mcc_back #(
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ctl     (q_ctl),
		.q_idx     (q_idx),
		.q_sym     (q_sym),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.unknown   (unknown),
		.last      (last)
	);

	// queue use by front and back
	`MCC_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "job popped from empty queue")
	`MCC_ASSERT_NOW(a_push_room, q_push, !q_full, "job pushed into full queue")
	`MCC_ASSERT_NEXT(a_push_visible, q_push, q_valid, "pushed job not visible to back")

endmodule

`default_nettype wire

[sim/morse_code_codec_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_code_codec_top_tb
// Self-checking bench for the Morse codec. The bench keeps its own trie,
// reverse code table and decode walk state. It builds the expected output
// words for every accepted input word and checks them in order against the
// result channel. Traffic runs in four parts: directed corner cases, random
// dictionary traffic with mostly well-formed codewords, a long output hold-off, and
// a steady stream with no idling.
// ----------------------------------------------------------------------------
`default_nettype none

module morse_code_codec_top_tb;
	import mcc_pkg::*;

	localparam int TRIE_NODES     = 127;
	localparam int TRIE_DEPTH     = 6;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int ITEM_TARGET    = 460;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              unk;
		logic              fin;
	} out_word_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	cmd_t              cmd;
	logic [CHAR_W-1:0] char_in;
	logic [CODE_W-1:0] code_bits;
	logic [LEN_W-1:0]  code_len;
	logic              out_valid;
	logic              out_ready;
	logic [CHAR_W-1:0] out_char;
	logic              unknown;
	logic              last;

	// bench copy of the dictionary and the decode walk
	logic [CHAR_W-1:0] trie_sym [TRIE_NODES];
	logic              trie_used [TRIE_NODES];
	logic [9:0]        rev_code [SYM_COUNT];
	int                cur_node;
	bit                word_open;
	bit                word_lost;

	out_word_t expected_q[$];

	bit idle_on;
	bit hold_req;
	int words_sent;
	int results_checked;
	int unknown_seen;
	int err_count;
	int quiet_cycles;

	morse_code_codec_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.char_in   (char_in),
		.code_bits (code_bits),
		.code_len  (code_len),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_char  (out_char),
		.unknown   (unknown),
		.last      (last)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// dictionary predictor
	// ------------------------------------------------------------------

	function automatic void clear_dictionary();
		foreach (trie_sym[i]) begin
			trie_sym[i]  = CH_NUL;
			trie_used[i] = 1'b0;
		end
		foreach (rev_code[i]) rev_code[i] = '0;
		trie_used[0] = 1'b1;
		cur_node     = 0;
		word_open    = 1'b0;
		word_lost    = 1'b0;
	endfunction

	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		return (c >= CH_LC_A && c <= CH_LC_Z) ? c - CASE_OFS : c;
	endfunction

	// first node holding s in dot-first preorder
	function automatic bit find_first(input int idx, input logic [2:0] depth,
		input logic [5:0] path, input logic [CHAR_W-1:0] s, output logic [9:0] code);
		code = '0;
		if (idx >= TRIE_NODES) return 1'b0;
		if (!trie_used[idx]) return 1'b0;
		if (trie_sym[idx] == s) begin
			code = {1'b1, depth, path};
			return 1'b1;
		end
		if (depth >= TRIE_DEPTH) return 1'b0;
		if (find_first(2 * idx + 1, depth + 3'd1, path, s, code)) return 1'b1;
		if (find_first(2 * idx + 2, depth + 3'd1, path | (6'd1 << depth), s, code))
			return 1'b1;
		return 1'b0;
	endfunction

	function automatic void update_reverse(input logic [CHAR_W-1:0] s);
		logic [9:0] code;
		if (s == CH_NUL) return;
		if (!find_first(0, 3'd0, 6'd0, s, code)) code = '0;
		rev_code[s] = code;
	endfunction

	function automatic out_word_t mk_word(input logic [CHAR_W-1:0] c, input logic u);
		out_word_t w;
		w.ch  = c;
		w.unk = u;
		w.fin = 1'b0;
		return w;
	endfunction

	// apply one accepted word to the bench state, queue what it emits
	function automatic void predict_word(input cmd_t c, input logic [CHAR_W-1:0] ch,
		input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
		out_word_t         res[$];
		int                idx;
		int                nxt;
		int                n_el;
		bit                sep;
		logic [CHAR_W-1:0] sym;
		logic [CHAR_W-1:0] old_sym;
		logic [9:0]        code;
		case (c)
			CMD_LOAD: begin
				if (len <= TRIE_DEPTH) begin
					idx = 0;
					for (int d = 0; d < len; d++) begin
						idx = 2 * idx + 1 + bits[d];
						trie_used[idx] = 1'b1;
					end
					sym = fold_case(ch);
					old_sym = trie_sym[idx];
					trie_sym[idx] = sym;
					if (old_sym != sym) update_reverse(old_sym);
					update_reverse(sym);
				end
			end
			CMD_DECODE: begin
				sep = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) ||
					(ch == CH_VT) || (ch == CH_FF) || (ch == CH_NL);
				if (sep) begin
					if (word_open) begin
						if (word_lost) res = {res, mk_word(CH_NUL, 1'b1)};
						else res = {res, mk_word(trie_sym[cur_node], 1'b0)};
					end
					cur_node  = 0;
					word_open = 1'b0;
					word_lost = 1'b0;
					if (ch == CH_NL) res = {res, mk_word(CH_SPACE, 1'b0)};
				end else begin
					word_open = 1'b1;
					if ((ch == CH_DOT || ch == CH_DASH) && !word_lost) begin
						nxt = 2 * cur_node + ((ch == CH_DOT) ? 1 : 2);
						if (nxt >= TRIE_NODES) word_lost = 1'b1;
						else if (!trie_used[nxt]) word_lost = 1'b1;
						else cur_node = nxt;
					end
				end
			end
			CMD_ENCODE: begin
				if (ch == CH_SPACE || ch == CH_NL) begin
					res = {res, mk_word(CH_NL, 1'b0)};
				end else begin
					code = rev_code[fold_case(ch)];
					if (code[9]) begin
						n_el = int'(code[8:6]);
						if (n_el > TRIE_DEPTH) n_el = TRIE_DEPTH;
						for (int d = 0; d < n_el; d++)
							res = {res, mk_word(code[d] ? CH_DASH : CH_DOT, 1'b0)};
						res = {res, mk_word(CH_SPACE, 1'b0)};
					end else begin
						res = {res, mk_word(CH_SPACE, 1'b1)};
					end
				end
			end
			default: begin
				clear_dictionary();
			end
		endcase
		if (res.size() > 0) res[res.size() - 1].fin = 1'b1;
		foreach (res[i]) expected_q = {expected_q, res[i]};
	endfunction

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------

	// entered and left at a falling edge
	task automatic send_word(input cmd_t c, input logic [CHAR_W-1:0] ch,
		input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
		logic [CODE_W-1:0] b;
		logic [LEN_W-1:0]  l;
		b = bits;
		l = len;
		// load fields are don't-care on other commands, so keep them moving
		if (c != CMD_LOAD) begin
			b = CODE_W'($urandom_range(0, 63));
			l = LEN_W'($urandom_range(0, 7));
		end
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= c;
		char_in   <= ch;
		code_bits <= b;
		code_len  <= l;
		do @(posedge clk); while (!(in_valid && in_ready));
		predict_word(c, ch, b, l);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_load(input logic [CHAR_W-1:0] ch, input logic [CODE_W-1:0] bits,
		input logic [LEN_W-1:0] len);
		send_word(CMD_LOAD, ch, bits, len);
	endtask

	task automatic load_random_entry();
		int                r;
		logic [CHAR_W-1:0] sym;
		logic [LEN_W-1:0]  len;
		r = $urandom_range(0, 99);
		if (r < 35) sym = 8'h41 + CHAR_W'($urandom_range(0, 25));
		else if (r < 70) sym = CH_LC_A + CHAR_W'($urandom_range(0, 25));
		else if (r < 80) sym = 8'h30 + CHAR_W'($urandom_range(0, 9));
		else sym = CHAR_W'($urandom_range(0, 255));
		if ($urandom_range(0, 99) < 85) len = LEN_W'($urandom_range(1, 4));
		else len = LEN_W'($urandom_range(0, 7));
		send_load(sym, CODE_W'($urandom_range(0, 63)), len);
	endtask

	// walk to a present node, sometimes overshoot or mix in noise, then close
	task automatic send_code_word();
		int                used_nodes[$];
		int                n;
		logic [CHAR_W-1:0] elems[$];
		logic [CHAR_W-1:0] seps[6];
		seps = '{CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF, CH_NL};
		foreach (trie_used[i]) if (trie_used[i]) used_nodes = {used_nodes, i};
		n = used_nodes[$urandom_range(0, used_nodes.size() - 1)];
		while (n > 0) begin
			if (n % 2 == 1) begin
				elems.push_front(CH_DOT);
				n = (n - 1) / 2;
			end else begin
				elems.push_front(CH_DASH);
				n = (n - 2) / 2;
			end
		end
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 2))
				elems = {elems, ($urandom_range(0, 1) ? CH_DOT : CH_DASH)};
		if ($urandom_range(0, 9) == 0)
			elems.insert($urandom_range(0, elems.size()),
				8'h41 + CHAR_W'($urandom_range(0, 57)));
		foreach (elems[i]) send_word(CMD_DECODE, elems[i], '0, '0);
		send_word(CMD_DECODE, seps[$urandom_range(0, 5)], '0, '0);
	endtask

	task automatic send_random_encode();
		int                used_nodes[$];
		int                r;
		logic [CHAR_W-1:0] ch;
		r = $urandom_range(0, 99);
		foreach (trie_sym[i])
			if (trie_used[i] && trie_sym[i] != CH_NUL) used_nodes = {used_nodes, i};
		if (r < 70 && used_nodes.size() > 0) begin
			ch = trie_sym[used_nodes[$urandom_range(0, used_nodes.size() - 1)]];
			if (ch >= 8'h41 && ch <= 8'h5A && $urandom_range(0, 1)) ch = ch + CASE_OFS;
		end else if (r < 80) begin
			ch = $urandom_range(0, 1) ? CH_SPACE : CH_NL;
		end else begin
			ch = CHAR_W'($urandom_range(0, 255));
		end
		send_word(CMD_ENCODE, ch, '0, '0);
	endtask

	// ------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------

	// ready with random stall bursts and one long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		out_word_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (unknown) unknown_seen++;
			if (expected_q.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result word, expected none, got char %h unknown %b last %b",
					$time, out_char, unknown, last);
			end else begin
				exp_w = expected_q.pop_front();
				if (out_char !== exp_w.ch) begin
					err_count++;
					$display("%0t: out_char mismatch, expected %h, got %h",
						$time, exp_w.ch, out_char);
				end
				if (unknown !== exp_w.unk) begin
					err_count++;
					$display("%0t: unknown mismatch, expected %b, got %b",
						$time, exp_w.unk, unknown);
				end
				if (last !== exp_w.fin) begin
					err_count++;
					$display("%0t: last mismatch, expected %b, got %b",
						$time, exp_w.fin, last);
				end
			end
		end
	end

	// watchdog on cycles with no handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results still pending",
				$time, expected_q.size());
			$display("morse_code_codec_top_tb failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_directed_cases();
		// newline as a separator with nothing open
		send_word(CMD_DECODE, CH_NL, '0, '0);
		// small dictionary: E, T, root symbol, an over-long code, deep six element code
		send_load(8'h65, 6'b000000, 3'd1);
		send_load(8'h74, 6'b000001, 3'd1);
		send_load(8'h52, 6'b000000, 3'd0);
		send_load(8'h71, 6'b111111, 3'd7);
		send_load(8'h3F, 6'b001100, 3'd6);
		// duplicate E deeper in preorder, and NUL at dot-dash
		send_load(8'h65, 6'b000000, 3'd2);
		send_load(CH_NUL, 6'b000010, 3'd2);
		// decode E, T plus newline space, root symbol, NUL node, lost path
		send_word(CMD_DECODE, CH_DOT, '0, '0);
		send_word(CMD_DECODE, CH_SPACE, '0, '0);
		send_word(CMD_DECODE, CH_DASH, '0, '0);
		send_word(CMD_DECODE, CH_NL, '0, '0);
		send_word(CMD_DECODE, 8'h78, '0, '0);
		send_word(CMD_DECODE, CH_FF, '0, '0);
		send_word(CMD_DECODE, CH_DOT, '0, '0);
		send_word(CMD_DECODE, CH_DASH, '0, '0);
		send_word(CMD_DECODE, CH_CR, '0, '0);
		send_word(CMD_DECODE, CH_DASH, '0, '0);
		send_word(CMD_DECODE, CH_DASH, '0, '0);
		send_word(CMD_DECODE, CH_VT, '0, '0);
		// encode found, space, newline, absent, NUL, longest code
		send_word(CMD_ENCODE, 8'h65, '0, '0);
		send_word(CMD_ENCODE, CH_SPACE, '0, '0);
		send_word(CMD_ENCODE, CH_NL, '0, '0);
		send_word(CMD_ENCODE, 8'h71, '0, '0);
		send_word(CMD_ENCODE, CH_NUL, '0, '0);
		send_word(CMD_ENCODE, 8'h3F, '0, '0);
		// overwrite E at dot, E falls back to dot-dot
		send_load(8'h41, 6'b000000, 3'd1);
		send_word(CMD_ENCODE, 8'h45, '0, '0);
		send_word(CMD_CLEAR, 8'hFF, '0, '0);
	endtask

	task automatic test_dictionary_traffic(input int stop_at);
		int pick;
		idle_on = 1'b1;
		repeat (12) load_random_entry();
		while (words_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				send_code_word();
			end else if (pick < 70) begin
				send_random_encode();
			end else if (pick < 78) begin
				load_random_entry();
			end else if (pick < 90) begin
				send_word(CMD_DECODE, CHAR_W'($urandom_range(0, 255)), '0, '0);
			end else if (pick < 92) begin
				send_word(CMD_CLEAR, CHAR_W'($urandom_range(0, 255)), '0, '0);
				repeat (6) load_random_entry();
			end else begin
				send_word(cmd_t'($urandom_range(0, 2)), CHAR_W'($urandom_range(0, 255)),
					CODE_W'($urandom_range(0, 63)), LEN_W'($urandom_range(0, 7)));
			end
		end
	endtask

	// long encodes against a receiver that holds off, so the input stalls
	task automatic test_output_backpressure();
		send_load(8'h3F, 6'b001100, 3'd6);
		send_load(8'h30, 6'b111111, 3'd6);
		hold_req = 1'b1;
		repeat (16) send_word(CMD_ENCODE, $urandom_range(0, 1) ? 8'h3F : 8'h30, '0, '0);
	endtask

	task automatic test_steady_stream();
		idle_on = 1'b0;
		while (words_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 2) == 0) send_random_encode();
			else send_code_word();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		in_valid        = 1'b0;
		cmd             = CMD_LOAD;
		char_in         = '0;
		code_bits       = '0;
		code_len        = '0;
		idle_on         = 1'b1;
		hold_req        = 1'b0;
		words_sent      = 0;
		results_checked = 0;
		unknown_seen    = 0;
		err_count       = 0;
		quiet_cycles    = 0;
		clear_dictionary();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_dictionary_traffic(ITEM_TARGET - 100);
		test_output_backpressure();
		test_steady_stream();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("run covered %0d input words and %0d result words, %0d flagged unknown",
			words_sent, results_checked, unknown_seen);
		$display("with loads, clears, decode walks, lost paths and a %0d cycle output hold-off",
			HOLD_CYCLES);
		if (err_count == 0) begin
			$display("morse_code_codec_top_tb passed");
		end else begin
			$display("morse_code_codec_top_tb failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/mcc_pkg.sv
rtl/core/mcc_ram.sv
rtl/core/mcc_queue.sv
rtl/core/mcc_front.sv
rtl/core/mcc_back.sv
rtl/core/morse_code_codec_top.sv
sim/morse_code_codec_top_tb.sv
